// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the timer table scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TABLE_DEPTH     = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_QUEUE_DEPTH = 32;  // power of two
  localparam int CMD_QUEUE_DEPTH = 2;   // power of two
  localparam int TIME_W          = 64;
  localparam int TAG_W           = 16;
  localparam int INDEX_W         = 4;
  localparam int TOTAL_W         = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  // when: deadline for add, current time otherwise
  typedef struct packed {
    action_t             action;
    logic [TIME_W-1:0]   when;
    logic [TIME_W-1:0]   interval;
    logic                rep;
    logic [TAG_W-1:0]    tag;
    logic [INDEX_W-1:0]  index;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] interval;
    logic              rep;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic               fired;
    logic [TAG_W-1:0]   tag;
    status_t            status;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } res_t;

endpackage

// ===== rtl/tts_front.sv =====
// ----------------------------------------------------------------------------
// tts_front
// Accepts input beats, decodes the action, precomputes the add deadline and
// holds the decoded commands in a short queue for the table engine.
// ----------------------------------------------------------------------------
module tts_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  logic [tts_pkg::TIME_W-1:0]   now_time,
  input  logic [tts_pkg::TIME_W-1:0]   interval,
  input  logic                         repeat_req,
  input  logic [tts_pkg::TAG_W-1:0]    callback_tag,
  input  logic [tts_pkg::INDEX_W-1:0]  entry_index,
  output logic                         cmd_valid,
  output tts_pkg::cmd_t                cmd,
  input  logic                         cmd_pop
);

  localparam int DEPTH = tts_pkg::CMD_QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  tts_pkg::cmd_t   q [0:DEPTH-1];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   cnt;
  tts_pkg::cmd_t   in_cmd;
  logic            acc;
  logic            deq;

  always_comb begin
    in_cmd.action   = tts_pkg::action_t'(action);
    in_cmd.when     = (in_cmd.action == tts_pkg::ACT_ADD) ? now_time + interval : now_time;
    in_cmd.interval = interval;
    in_cmd.rep      = repeat_req;
    in_cmd.tag      = callback_tag;
    in_cmd.index    = entry_index;
  end

  assign full      = (cnt == DEPTH_C);
  assign acc       = push && !full;
  assign cmd_valid = (cnt != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (acc) begin
      q[wp] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (acc) begin
        wp <= wp + 1'b1;
      end
      if (deq) begin
        rp <= rp + 1'b1;
      end
      unique case ({acc, deq})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ===== rtl/tts_engine.sv =====
// ----------------------------------------------------------------------------
// tts_engine
// Owns the timer table memory. Runs add, clear and remove/tick walks, one
// table entry per cycle, compacting the table in place.
// ----------------------------------------------------------------------------
module tts_engine #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  tts_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  input  logic           res_space,
  output logic           res_push,
  output tts_pkg::res_t  res_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = (CW > tts_pkg::INDEX_W) ? CW : tts_pkg::INDEX_W;
  localparam int TW = tts_pkg::TOTAL_W;
  localparam int NW = $clog2(tts_pkg::MAX_RESULTS + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [NW-1:0] MAX_C   = NW'(tts_pkg::MAX_RESULTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  tts_pkg::entry_t  mem [0:TABLE_DEPTH-1];
  tts_pkg::entry_t  rd_data;
  tts_pkg::entry_t  upd;
  tts_pkg::entry_t  wdata;
  logic [AW-1:0]    waddr;
  logic             we;

  state_t                       state;
  logic [CW-1:0]                count;
  logic                         is_tick;
  logic [tts_pkg::TIME_W-1:0]   now_q;
  logic [CW-1:0]                drop_pos;
  logic [CW-1:0]                issue_ptr;
  logic [CW-1:0]                rd_pos;
  logic                         rd_vld;
  logic [CW-1:0]                wr_ptr;
  logic [CW-1:0]                live;
  logic                         pend_vld;
  logic [tts_pkg::TAG_W-1:0]    pend_tag;
  logic [TW-1:0]                pend_total;
  logic [NW-1:0]                nres;

  logic            start;
  logic            issue;
  logic            walk_end;
  logic            bad_index;
  logic            tab_full;
  logic            hit;
  logic            drop;
  logic [CW-1:0]   live_after;
  logic            take;

  assign start     = (state == S_IDLE) && cmd_valid && res_space;
  assign cmd_pop   = start;
  assign issue     = (state == S_WALK) && (issue_ptr < count);
  assign walk_end  = (state == S_WALK) && !issue && !rd_vld;
  assign bad_index = IW'(cmd.index) >= IW'(count);
  assign tab_full  = (count >= DEPTH_C);
  assign hit       = rd_vld && is_tick && (now_q >= rd_data.deadline);
  assign drop      = rd_vld && (is_tick ? (hit && !rd_data.rep) : (rd_pos == drop_pos));
  assign live_after = drop ? live - 1'b1 : live;
  assign take      = hit && (nres < MAX_C);

  always_comb begin
    upd = rd_data;
    if (hit) begin
      upd.deadline = rd_data.deadline + rd_data.interval;
    end
  end

  // single write port: add in idle, write-back during a walk
  always_comb begin
    we    = 1'b0;
    waddr = wr_ptr[AW-1:0];
    wdata = upd;
    if (start && (cmd.action == tts_pkg::ACT_ADD) && !tab_full) begin
      we             = 1'b1;
      waddr          = count[AW-1:0];
      wdata.deadline = cmd.when;
      wdata.interval = cmd.interval;
      wdata.rep      = cmd.rep;
      wdata.tag      = cmd.tag;
    end else if (rd_vld && !drop) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rd_data <= mem[issue_ptr[AW-1:0]];
    end
  end

  always_comb begin
    res_push = 1'b0;
    res_data = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          res_data.last = 1'b1;
          unique case (cmd.action)
            tts_pkg::ACT_ADD: begin
              res_push        = 1'b1;
              res_data.status = tab_full ? tts_pkg::ST_FULL : tts_pkg::ST_OK;
              res_data.total  = tab_full ? TW'(count) : TW'(count + 1'b1);
            end
            tts_pkg::ACT_TICK: begin
              res_push = 1'b0;
            end
            tts_pkg::ACT_REMOVE: begin
              res_push        = bad_index;
              res_data.status = tts_pkg::ST_BAD_INDEX;
              res_data.total  = TW'(count);
            end
            tts_pkg::ACT_CLEAR: begin
              res_push = 1'b1;
            end
            default: res_push = 1'b0;
          endcase
        end
      end
      S_WALK: begin
        // a newer hit flushes the held one as a non-final beat
        if (take && pend_vld) begin
          res_push       = 1'b1;
          res_data.fired = 1'b1;
          res_data.tag   = pend_tag;
          res_data.total = pend_total;
        end
      end
      S_DONE: begin
        res_push       = 1'b1;
        res_data.fired = pend_vld;
        res_data.tag   = pend_vld ? pend_tag : '0;
        res_data.total = TW'(live);
        res_data.last  = 1'b1;
      end
      default: res_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      rd_vld   <= 1'b0;
      pend_vld <= 1'b0;
      nres     <= '0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        issue_ptr <= issue_ptr + 1'b1;
        rd_pos    <= issue_ptr;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            is_tick   <= (cmd.action == tts_pkg::ACT_TICK);
            now_q     <= cmd.when;
            drop_pos  <= CW'(cmd.index);
            issue_ptr <= (cmd.action == tts_pkg::ACT_TICK) ? '0 : CW'(cmd.index);
            wr_ptr    <= (cmd.action == tts_pkg::ACT_TICK) ? '0 : CW'(cmd.index);
            live      <= count;
            pend_vld  <= 1'b0;
            nres      <= '0;
            unique case (cmd.action)
              tts_pkg::ACT_ADD: begin
                if (!tab_full) begin
                  count <= count + 1'b1;
                end
              end
              tts_pkg::ACT_TICK: state <= S_WALK;
              tts_pkg::ACT_REMOVE: begin
                if (!bad_index) begin
                  state <= S_WALK;
                end
              end
              tts_pkg::ACT_CLEAR: count <= '0;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_WALK: begin
          if (rd_vld) begin
            if (!drop) begin
              wr_ptr <= wr_ptr + 1'b1;
            end
            live <= live_after;
            if (take) begin
              pend_vld   <= 1'b1;
              pend_tag   <= rd_data.tag;
              pend_total <= TW'(live_after);
              nres       <= nres + 1'b1;
            end
          end
          if (walk_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          count <= live;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above table depth");

  a_write_behind_read: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (wr_ptr <= rd_pos))
    else $error("compaction write pointer passed read position");

  a_done_one_beat: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> (state == S_IDLE) && !rd_vld)
    else $error("walk finish did not return to idle");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    nres <= MAX_C)
    else $error("fired result count above limit");

endmodule

// ===== rtl/tts_res_queue.sv =====
// ----------------------------------------------------------------------------
// tts_res_queue
// Result queue between the table engine and the output port. Reports room
// for a full burst of results from one command.
// ----------------------------------------------------------------------------
module tts_res_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tts_pkg::res_t  push_data,
  output logic           space,
  output logic           empty,
  input  logic           pop,
  output tts_pkg::res_t  head
);

  localparam int DEPTH = tts_pkg::RES_QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ROOM_C  = CW'(DEPTH - tts_pkg::MAX_RESULTS);

  tts_pkg::res_t  q [0:DEPTH-1];
  logic [AW-1:0]  wp;
  logic [AW-1:0]  rp;
  logic [CW-1:0]  cnt;
  logic           deq;

  assign empty = (cnt == '0);
  assign space = (cnt <= ROOM_C);
  assign deq   = pop && !empty;
  assign head  = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (deq) begin
        rp <= rp + 1'b1;
      end
      unique case ({push, deq})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt != DEPTH_C) || deq)
    else $error("result queue overflow");

endmodule

// ===== rtl/timer_table_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// timer_table_scheduler_top
// Timer table with one-shot and repeating entries, queue-style ports.
// ----------------------------------------------------------------------------
// Input beats go through a two-entry command queue into the table engine,
// which owns a table memory with one read and one write port and handles one
// command at a time. Add, clear and a bad-index remove finish in idle, with no
// walk. A tick walks the whole table one entry per cycle: the engine starts
// the walk, reads each entry, drains the read and write-back pipe and then
// posts the final result. A remove takes the same steps but walks from the
// given index to the end.
// The memory's one read and one write port set that pace. The engine starts a
// command only when the result queue has room for a full burst of results
// (up to 16 per tick), so a slow reader stalls new commands, never a walk.
// The table memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module timer_table_scheduler_top #(
  parameter int TABLE_DEPTH = tts_pkg::TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  logic [tts_pkg::TIME_W-1:0]   now_time,
  input  logic [tts_pkg::TIME_W-1:0]   interval,
  input  logic                         repeat_req,
  input  logic [tts_pkg::TAG_W-1:0]    callback_tag,
  input  logic [tts_pkg::INDEX_W-1:0]  entry_index,
  output logic                         empty,
  input  logic                         pop,
  output logic                         fired,
  output logic [tts_pkg::TAG_W-1:0]    fired_tag,
  output logic [1:0]                   status,
  output logic [tts_pkg::TOTAL_W-1:0]  entry_total,
  output logic                         last
);

  logic           cmd_valid;
  tts_pkg::cmd_t  cmd;
  logic           cmd_pop;
  logic           res_space;
  logic           res_push;
  tts_pkg::res_t  res_data;
  tts_pkg::res_t  head;

  tts_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .now_time     (now_time),
    .interval     (interval),
    .repeat_req   (repeat_req),
    .callback_tag (callback_tag),
    .entry_index  (entry_index),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  tts_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_space (res_space),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  tts_res_queue u_res_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .space     (res_space),
    .empty     (empty),
    .pop       (pop),
    .head      (head)
  );

  assign fired       = head.fired;
  assign fired_tag   = head.tag;
  assign status      = head.status;
  assign entry_total = head.total;
  assign last        = head.last;

endmodule
